// ===== hdl/efc_pkg.sv =====
`default_nettype none

package efc_pkg;

  localparam int MAX_FRAME_BYTES_DEFAULT = 65535;
  localparam int HEADER_BYTES            = 36;
  localparam int MAX_PAYLOAD_LENGTH      = 65535;

  // FNV-1a-64 offset basis; the prime 0x100000001b3 is folded into fnv_mul
  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

  // Header byte positions
  localparam int POS_VERSION  = 0;
  localparam int POS_TYPE     = 1;
  localparam int POS_FLAGS    = 2;
  localparam int POS_HOPS     = 3;
  localparam int POS_DEST_LO  = 12;
  localparam int POS_SRC_HI   = 20;
  localparam int POS_SRC_LO   = 28;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MY_ID_HIGH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MY_ID_LOW      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_ID_HIGH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_ID_LOW   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXP_VERSION    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOP_LIMIT      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_GATEWAY_MODE   = 3'd6;

  localparam logic [7:0] EXP_VERSION_RESET = 8'd1;
  localparam logic [7:0] HOP_LIMIT_RESET   = 8'd8;

  // Status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_SHORT       = 2'd1;
  localparam logic [1:0] STATUS_BAD_VERSION = 2'd2;

  // Disposition codes
  localparam logic [1:0] DISP_DROP    = 2'd0;
  localparam logic [1:0] DISP_LOCAL   = 2'd1;
  localparam logic [1:0] DISP_FORWARD = 2'd2;

  // Message type codes
  localparam logic [7:0] TYPE_UNKNOWN   = 8'd0;
  localparam logic [7:0] TYPE_PEER      = 8'd1;
  localparam logic [7:0] TYPE_GROUP     = 8'd2;
  localparam logic [7:0] TYPE_BROADCAST = 8'd3;

  typedef struct packed {
    logic [63:0] my_id_high;
    logic [63:0] my_id_low;
    logic [63:0] group_id_high;
    logic [63:0] group_id_low;
    logic [7:0]  expected_version;
    logic [7:0]  hop_limit;
    logic        gateway_mode;
  } cfg_t;

  // Frame state as seen after the current byte has been taken in
  typedef struct packed {
    logic        short_frame;
    logic        version_ok;
    logic [7:0]  msg_type;
    logic [7:0]  flag_bits;
    logic [7:0]  hop_num;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [63:0] hash;
    logic [15:0] body_length;
  } frame_view_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  disposition;
    logic        rebroadcast;
    logic [63:0] fingerprint;
    logic [7:0]  msg_type;
    logic [7:0]  flag_bits;
    logic [7:0]  hop_num;
    logic [15:0] body_length;
    logic [63:0] src_id_high;
    logic [63:0] src_id_low;
  } result_t;

  // h * 0x100000001b3 mod 2^64 as shift-add: 2^40 + 0x1b3 (256+128+32+16+2+1)
  function automatic logic [63:0] fnv_mul(input logic [63:0] h);
    fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/efc_ifs.sv =====
`default_nettype none

interface efc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface efc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  disposition;
  logic        rebroadcast;
  logic [63:0] fingerprint;
  logic [7:0]  msg_type;
  logic [7:0]  flag_bits;
  logic [7:0]  hop_num;
  logic [15:0] body_length;
  logic [63:0] src_id_high;
  logic [63:0] src_id_low;

  modport source (output valid, output status, output disposition, output rebroadcast,
                  output fingerprint, output msg_type, output flag_bits, output hop_num,
                  output body_length, output src_id_high, output src_id_low,
                  input ready);
  modport sink   (input valid, input status, input disposition, input rebroadcast,
                  input fingerprint, input msg_type, input flag_bits, input hop_num,
                  input body_length, input src_id_high, input src_id_low,
                  output ready);
endinterface

interface efc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [efc_pkg::CFG_INDEX_W-1:0] index;
  logic [63:0]                   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/envelope_frame_classifier_unit.sv =====
// Envelope frame classifier.
// frame_in carries a received frame one byte per transaction, last_byte set
// on its final byte. The first 36 bytes are the header (version, type, flags,
// hops, 128-bit destination, 128-bit source); an FNV-1a-64 fingerprint runs
// from byte 20 to the end. Each frame gives exactly one transaction on
// result_out, made on its last byte; other bytes give none.
// cfg writes the seven registers by index; it is always ready and must only
// be used while no frame is in flight. Unmapped indexes are dropped.
// Throughput: one byte per cycle, sustained across frame boundaries except
// where a last byte waits on a stalled result_out. The path that sets the
// clock is the hash step (xor plus a seven-term shift-add for the FNV prime)
// feeding the result register. A last byte passes from the input register
// into the result register, whose contents drive result_out with valid set.
// When result_out stalls, the waiting result holds; a last byte then waits
// in the input register and frame_in drops ready, but other bytes keep
// flowing. Reset (rst, synchronous) empties both registers, clears the frame
// state and loads the register reset values.
`default_nettype none

module envelope_frame_classifier_unit #(
  parameter int MAX_FRAME_BYTES = efc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  efc_in_if.sink     frame_in,
  efc_out_if.source  result_out,
  efc_cfg_if.sink    cfg
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  logic out_valid;
  efc_pkg::result_t out_data;

  logic out_free, s1_fire, in_fire;

  efc_pkg::cfg_t        regs;
  efc_pkg::frame_view_t view;
  efc_pkg::result_t     res;

  // only a last byte needs the result slot
  assign out_free       = !out_valid || result_out.ready;
  assign s1_fire        = s1_valid && (!s1_last || out_free);
  assign frame_in.ready = !s1_valid || s1_fire;
  assign in_fire        = frame_in.valid && frame_in.ready;

  efc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  efc_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (s1_fire),
    .data_byte        (s1_byte),
    .frame_end        (s1_last),
    .expected_version (regs.expected_version),
    .view             (view)
  );

  efc_decide u_decide (
    .view (view),
    .cfg  (regs),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_byte <= frame_in.frame_byte;
      s1_last <= frame_in.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      out_data <= res;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.status         = out_data.status;
  assign result_out.disposition    = out_data.disposition;
  assign result_out.rebroadcast    = out_data.rebroadcast;
  assign result_out.fingerprint    = out_data.fingerprint;
  assign result_out.msg_type       = out_data.msg_type;
  assign result_out.flag_bits      = out_data.flag_bits;
  assign result_out.hop_num        = out_data.hop_num;
  assign result_out.body_length    = out_data.body_length;
  assign result_out.src_id_high    = out_data.src_id_high;
  assign result_out.src_id_low     = out_data.src_id_low;

  // a held byte is never dropped or overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("input register lost a byte");

  // bad status always drops
  a_bad_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != efc_pkg::STATUS_OK) |->
      (out_data.disposition == efc_pkg::DISP_DROP) && !out_data.rebroadcast &&
      (out_data.body_length == 16'd0))
    else $error("bad frame not dropped");

  // rebroadcast only on a locally delivered broadcast
  a_rebro: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.rebroadcast |->
      (out_data.msg_type == efc_pkg::TYPE_BROADCAST) &&
      (out_data.disposition == efc_pkg::DISP_LOCAL))
    else $error("rebroadcast on non-broadcast frame");

  // forwarding needs gateway mode
  a_fwd: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.disposition == efc_pkg::DISP_FORWARD) |->
      regs.gateway_mode && (out_data.msg_type == efc_pkg::TYPE_PEER))
    else $error("forward without gateway mode");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("registers not empty after reset");

endmodule

`default_nettype wire

// ===== hdl/efc_cfg_regs.sv =====
`default_nettype none

module efc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  efc_cfg_if.sink       cfg,
  output efc_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.my_id_high       <= '0;
      regs.my_id_low        <= '0;
      regs.group_id_high    <= '0;
      regs.group_id_low     <= '0;
      regs.expected_version <= efc_pkg::EXP_VERSION_RESET;
      regs.hop_limit        <= efc_pkg::HOP_LIMIT_RESET;
      regs.gateway_mode     <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        efc_pkg::CFG_MY_ID_HIGH:    regs.my_id_high       <= cfg.data;
        efc_pkg::CFG_MY_ID_LOW:     regs.my_id_low        <= cfg.data;
        efc_pkg::CFG_GROUP_ID_HIGH: regs.group_id_high    <= cfg.data;
        efc_pkg::CFG_GROUP_ID_LOW:  regs.group_id_low     <= cfg.data;
        efc_pkg::CFG_EXP_VERSION:   regs.expected_version <= cfg.data[7:0];
        efc_pkg::CFG_HOP_LIMIT:     regs.hop_limit        <= cfg.data[7:0];
        efc_pkg::CFG_GATEWAY_MODE:  regs.gateway_mode     <= cfg.data[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/efc_parser.sv =====
`default_nettype none

module efc_parser #(
  parameter int MAX_FRAME_BYTES = efc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 frame_end,
  input  logic [7:0]           expected_version,
  output efc_pkg::frame_view_t view
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LW = (PW > 17) ? PW : 17;

  logic [PW-1:0] pos, pos_next;
  logic [63:0]   hash, hash_next;
  logic [7:0]    held_type, held_type_next;
  logic [7:0]    held_flags, held_flags_next;
  logic [7:0]    held_hops, held_hops_next;
  logic [63:0]   dest_hi, dest_hi_next;
  logic [63:0]   dest_lo, dest_lo_next;
  logic [63:0]   src_hi, src_hi_next;
  logic [63:0]   src_lo, src_lo_next;
  logic          version_matched, version_matched_next;
  logic [LW-1:0] total_w, over;

  always_comb begin
    held_type_next       = held_type;
    held_flags_next      = held_flags;
    held_hops_next       = held_hops;
    dest_hi_next         = dest_hi;
    dest_lo_next         = dest_lo;
    src_hi_next          = src_hi;
    src_lo_next          = src_lo;
    version_matched_next = version_matched;

    if (pos == PW'(efc_pkg::POS_VERSION)) begin
      version_matched_next = (data_byte == expected_version);
    end else if (pos == PW'(efc_pkg::POS_TYPE)) begin
      held_type_next = data_byte;
    end else if (pos == PW'(efc_pkg::POS_FLAGS)) begin
      held_flags_next = data_byte;
    end else if (pos == PW'(efc_pkg::POS_HOPS)) begin
      held_hops_next = data_byte;
    end else if (pos < PW'(efc_pkg::POS_DEST_LO)) begin
      dest_hi_next = {dest_hi[55:0], data_byte};
    end else if (pos < PW'(efc_pkg::POS_SRC_HI)) begin
      dest_lo_next = {dest_lo[55:0], data_byte};
    end else if (pos < PW'(efc_pkg::POS_SRC_LO)) begin
      src_hi_next = {src_hi[55:0], data_byte};
    end else if (pos < PW'(efc_pkg::HEADER_BYTES)) begin
      src_lo_next = {src_lo[55:0], data_byte};
    end

    // fingerprint covers source id and payload
    if (pos >= PW'(efc_pkg::POS_SRC_HI)) begin
      hash_next = efc_pkg::fnv_mul(hash ^ {56'd0, data_byte});
    end else begin
      hash_next = hash;
    end

    // byte count sticks at the frame limit
    if (pos < PW'(MAX_FRAME_BYTES)) begin
      pos_next = pos + PW'(1);
    end else begin
      pos_next = pos;
    end

    total_w = LW'(pos_next);
    over    = total_w - LW'(efc_pkg::HEADER_BYTES);
  end

  always_comb begin
    view.short_frame = (pos_next < PW'(efc_pkg::HEADER_BYTES));
    view.version_ok  = version_matched_next;
    view.msg_type    = held_type_next;
    view.flag_bits   = held_flags_next;
    view.hop_num     = held_hops_next;
    view.dest_high   = dest_hi_next;
    view.dest_low    = dest_lo_next;
    view.src_high    = src_hi_next;
    view.src_low     = src_lo_next;
    view.hash        = hash_next;
    if (over > LW'(efc_pkg::MAX_PAYLOAD_LENGTH)) begin
      view.body_length = 16'hFFFF;
    end else begin
      view.body_length = over[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && frame_end)) begin
      pos             <= '0;
      hash            <= efc_pkg::FNV_BASIS;
      held_type       <= '0;
      held_flags      <= '0;
      held_hops       <= '0;
      dest_hi         <= '0;
      dest_lo         <= '0;
      src_hi          <= '0;
      src_lo          <= '0;
      version_matched <= 1'b0;
    end else if (step) begin
      pos             <= pos_next;
      hash            <= hash_next;
      held_type       <= held_type_next;
      held_flags      <= held_flags_next;
      held_hops       <= held_hops_next;
      dest_hi         <= dest_hi_next;
      dest_lo         <= dest_lo_next;
      src_hi          <= src_hi_next;
      src_lo          <= src_lo_next;
      version_matched <= version_matched_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/efc_decide.sv =====
`default_nettype none

module efc_decide (
  input  efc_pkg::frame_view_t view,
  input  efc_pkg::cfg_t        cfg,
  output efc_pkg::result_t     res
);

  logic below, to_me, to_group;

  always_comb begin
    below    = (view.hop_num < cfg.hop_limit);
    to_me    = (view.dest_high == cfg.my_id_high) && (view.dest_low == cfg.my_id_low);
    to_group = ((cfg.group_id_high | cfg.group_id_low) != 64'd0) &&
               (view.dest_high == cfg.group_id_high) && (view.dest_low == cfg.group_id_low);

    res = '0;
    if (view.short_frame) begin
      res.status = efc_pkg::STATUS_SHORT;
    end else if (!view.version_ok) begin
      res.status = efc_pkg::STATUS_BAD_VERSION;
    end else begin
      res.status         = efc_pkg::STATUS_OK;
      res.fingerprint    = view.hash;
      res.msg_type       = view.msg_type;
      res.flag_bits      = view.flag_bits;
      res.hop_num        = view.hop_num;
      res.body_length    = view.body_length;
      res.src_id_high    = view.src_high;
      res.src_id_low     = view.src_low;
      unique case (view.msg_type)
        efc_pkg::TYPE_BROADCAST: begin
          res.disposition = efc_pkg::DISP_LOCAL;
          res.rebroadcast = cfg.gateway_mode && below;
        end
        efc_pkg::TYPE_PEER: begin
          if (to_me) begin
            res.disposition = efc_pkg::DISP_LOCAL;
          end else if (cfg.gateway_mode && below) begin
            res.disposition = efc_pkg::DISP_FORWARD;
          end else begin
            res.disposition = efc_pkg::DISP_DROP;
          end
        end
        efc_pkg::TYPE_GROUP: begin
          res.disposition = to_group ? efc_pkg::DISP_LOCAL : efc_pkg::DISP_DROP;
        end
        default: res.disposition = efc_pkg::DISP_DROP;  // unknown type
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/efc_verdict_checker.sv =====
`timescale 1ns / 1ps

// Watches all three channels, predicts the classification of each frame and
// scores every result transaction against the oldest prediction.
module efc_verdict_checker (
  input  logic clk,
  input  logic rst,
  efc_in_if    frame_in,
  efc_out_if   result_out,
  efc_cfg_if   cfg,
  output int   mismatch_count,
  output int   verdicts_pending
);

  localparam int          FRAME_BYTE_CAP = efc_pkg::MAX_FRAME_BYTES_DEFAULT;
  localparam logic [63:0] FNV_PRIME      = 64'h0000_0100_0000_01b3;
  localparam int          REPORT_LIMIT   = 10;

  efc_pkg::cfg_t    node_cfg;
  logic [15:0]      byte_count;
  logic [63:0]      fingerprint_acc;
  logic [7:0]       hdr_type;
  logic [7:0]       hdr_flags;
  logic [7:0]       hdr_hops;
  logic [63:0]      dest_hi;
  logic [63:0]      dest_lo;
  logic [63:0]      src_hi;
  logic [63:0]      src_lo;
  logic             version_seen_ok;
  efc_pkg::result_t verdict_q[$];
  efc_pkg::result_t oldest;
  int               failures = 0;

  function automatic void clear_frame();
    byte_count      = '0;
    fingerprint_acc = efc_pkg::FNV_BASIS;
    hdr_type        = '0;
    hdr_flags       = '0;
    hdr_hops        = '0;
    dest_hi         = '0;
    dest_lo         = '0;
    src_hi          = '0;
    src_lo          = '0;
    version_seen_ok = 1'b0;
  endfunction

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("%0t ns: mismatch: %s", $time, what);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] got,
                                      input logic [63:0] want);
    if (got !== want)
      note_failure($sformatf("%s expected %h, got %h", name, want, got));
  endfunction

  // Take one frame byte; on the last byte queue the verdict for the frame.
  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    int               pos;
    int               total;
    int               plen;
    logic             below;
    efc_pkg::result_t v;
    pos = int'(byte_count);
    if (pos == efc_pkg::POS_VERSION)      version_seen_ok = (b == node_cfg.expected_version);
    else if (pos == efc_pkg::POS_TYPE)    hdr_type = b;
    else if (pos == efc_pkg::POS_FLAGS)   hdr_flags = b;
    else if (pos == efc_pkg::POS_HOPS)    hdr_hops = b;
    else if (pos < efc_pkg::POS_DEST_LO)  dest_hi = {dest_hi[55:0], b};
    else if (pos < efc_pkg::POS_SRC_HI)   dest_lo = {dest_lo[55:0], b};
    else if (pos < efc_pkg::POS_SRC_LO)   src_hi = {src_hi[55:0], b};
    else if (pos < efc_pkg::HEADER_BYTES) src_lo = {src_lo[55:0], b};
    if (pos >= efc_pkg::POS_SRC_HI)
      fingerprint_acc = (fingerprint_acc ^ {56'd0, b}) * FNV_PRIME;
    if (pos < FRAME_BYTE_CAP)
      byte_count = byte_count + 16'd1;
    if (!last)
      return;

    total = int'(byte_count);
    v = '0;
    if (total < efc_pkg::HEADER_BYTES) begin
      v.status = efc_pkg::STATUS_SHORT;
    end else if (!version_seen_ok) begin
      v.status = efc_pkg::STATUS_BAD_VERSION;
    end else begin
      v.status = efc_pkg::STATUS_OK;
      below = hdr_hops < node_cfg.hop_limit;
      v.disposition = efc_pkg::DISP_DROP;
      case (hdr_type)
        efc_pkg::TYPE_BROADCAST: begin
          v.disposition = efc_pkg::DISP_LOCAL;
          v.rebroadcast = node_cfg.gateway_mode && below;
        end
        efc_pkg::TYPE_PEER: begin
          if (dest_hi == node_cfg.my_id_high && dest_lo == node_cfg.my_id_low)
            v.disposition = efc_pkg::DISP_LOCAL;
          else if (node_cfg.gateway_mode && below)
            v.disposition = efc_pkg::DISP_FORWARD;
        end
        efc_pkg::TYPE_GROUP: begin
          if ((node_cfg.group_id_high | node_cfg.group_id_low) != 64'd0 &&
              dest_hi == node_cfg.group_id_high && dest_lo == node_cfg.group_id_low)
            v.disposition = efc_pkg::DISP_LOCAL;
        end
        default: ;
      endcase
      plen = total - efc_pkg::HEADER_BYTES;
      if (plen > efc_pkg::MAX_PAYLOAD_LENGTH)
        plen = efc_pkg::MAX_PAYLOAD_LENGTH;
      v.fingerprint    = fingerprint_acc;
      v.msg_type       = hdr_type;
      v.flag_bits      = hdr_flags;
      v.hop_num        = hdr_hops;
      v.body_length    = 16'(plen);
      v.src_id_high    = src_hi;
      v.src_id_low     = src_lo;
    end
    verdict_q.push_back(v);
    clear_frame();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      node_cfg = '{my_id_high: '0, my_id_low: '0, group_id_high: '0, group_id_low: '0,
                   expected_version: efc_pkg::EXP_VERSION_RESET,
                   hop_limit: efc_pkg::HOP_LIMIT_RESET, gateway_mode: 1'b0};
      clear_frame();
      verdict_q.delete();
    end else begin
      // results first: a result never belongs to a byte taken at the same edge
      if (result_out.valid && result_out.ready) begin
        if (verdict_q.size() == 0) begin
          note_failure("result transaction with nothing expected");
        end else begin
          oldest = verdict_q.pop_front();
          check_field("status", 64'(result_out.status), 64'(oldest.status));
          check_field("disposition", 64'(result_out.disposition), 64'(oldest.disposition));
          check_field("rebroadcast", 64'(result_out.rebroadcast), 64'(oldest.rebroadcast));
          check_field("fingerprint", result_out.fingerprint, oldest.fingerprint);
          check_field("msg_type", 64'(result_out.msg_type), 64'(oldest.msg_type));
          check_field("flag_bits", 64'(result_out.flag_bits), 64'(oldest.flag_bits));
          check_field("hop_num", 64'(result_out.hop_num), 64'(oldest.hop_num));
          check_field("body_length", 64'(result_out.body_length),
                      64'(oldest.body_length));
          check_field("src_id_high", result_out.src_id_high, oldest.src_id_high);
          check_field("src_id_low", result_out.src_id_low, oldest.src_id_low);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          efc_pkg::CFG_MY_ID_HIGH:    node_cfg.my_id_high       = cfg.data;
          efc_pkg::CFG_MY_ID_LOW:     node_cfg.my_id_low        = cfg.data;
          efc_pkg::CFG_GROUP_ID_HIGH: node_cfg.group_id_high    = cfg.data;
          efc_pkg::CFG_GROUP_ID_LOW:  node_cfg.group_id_low     = cfg.data;
          efc_pkg::CFG_EXP_VERSION:   node_cfg.expected_version = cfg.data[7:0];
          efc_pkg::CFG_HOP_LIMIT:     node_cfg.hop_limit        = cfg.data[7:0];
          efc_pkg::CFG_GATEWAY_MODE:  node_cfg.gateway_mode     = cfg.data[0];
          default: ;
        endcase
      end
      if (frame_in.valid && frame_in.ready)
        absorb_byte(frame_in.frame_byte, frame_in.last_byte);
    end
    verdicts_pending <= verdict_q.size();
    mismatch_count   <= failures;
  end

endmodule

// ===== bench/envelope_frame_classifier_unit_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the envelope frame classifier. Scoring is done by
// efc_verdict_checker, which sits beside the block and sees every transaction.
module envelope_frame_classifier_unit_tb;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [efc_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = 3'd7;

  localparam int    RANDOM_PHASES        = 4;
  localparam int    RANDOM_BYTES         = 260;
  localparam int    MIN_FRAMES_PER_PHASE = 2;
  localparam int    SETTLE_CYCLES        = 4;
  localparam longint TIMEOUT_NS          = 24_000_000;

  // Receiver behaviour, rotated in turn through the four styles below
  typedef enum logic [1:0] {
    DRAIN_ALWAYS,
    DRAIN_COIN,
    DRAIN_SPARSE,
    DRAIN_PERIODIC
  } drain_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  efc_in_if  frame_in ();
  efc_out_if result_out ();
  efc_cfg_if cfg ();

  int verdict_fails;
  int verdicts_pending;

  envelope_frame_classifier_unit dut (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_in),
    .result_out (result_out),
    .cfg        (cfg)
  );

  efc_verdict_checker verdict_check (
    .clk              (clk),
    .rst              (rst),
    .frame_in         (frame_in),
    .result_out       (result_out),
    .cfg              (cfg),
    .mismatch_count   (verdict_fails),
    .verdicts_pending (verdicts_pending)
  );

  always #6 clk = ~clk;

  // Hard stop in case the block hangs a handshake
  initial begin
    #(TIMEOUT_NS);
    $display("envelope_frame_classifier_unit_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: ready follows a rotating pattern so stalls land on every phase
  // of a frame, including long runs with no stall at all.
  // ---------------------------------------------------------------------------
  int           drain_tick;
  drain_style_t drain_style;

  always @(posedge clk) begin
    if (rst) begin
      drain_tick        <= 0;
      result_out.ready  <= 1'b0;
    end else begin
      drain_tick  <= drain_tick + 1;
      drain_style  = drain_style_t'((drain_tick / 53) % 4);
      case (drain_style)
        DRAIN_ALWAYS:   result_out.ready <= 1'b1;
        DRAIN_COIN:     result_out.ready <= 1'($urandom_range(0, 1));
        DRAIN_SPARSE:   result_out.ready <= ($urandom_range(0, 4) == 0);
        DRAIN_PERIODIC: result_out.ready <= (drain_tick % 7 == 0);
        default:        result_out.ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame side
  // ---------------------------------------------------------------------------
  logic [7:0]    frame_bytes[$];   // frame being assembled for sending
  efc_pkg::cfg_t live_cfg;         // settings the block currently holds
  int            burst_left;

  // One byte transaction. Bursts of random length, random gaps between them;
  // valid stays high across back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        frame_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
    end
    frame_in.valid      <= 1'b1;
    frame_in.frame_byte <= b;
    frame_in.last_byte  <= last;
    do @(posedge clk); while (!frame_in.ready);
    burst_left--;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  // big-endian, first byte is the top byte
  task automatic push_u64(input logic [63:0] v);
    for (int i = 7; i >= 0; i--)
      frame_bytes.push_back(v[i*8 +: 8]);
  endtask

  task automatic make_frame(input logic [7:0] ver, input logic [7:0] kind,
                            input logic [7:0] flags, input logic [7:0] hops,
                            input logic [63:0] dst_hi, input logic [63:0] dst_lo,
                            input logic [63:0] src_hi, input logic [63:0] src_lo,
                            input int extra_bytes);
    frame_bytes.push_back(ver);
    frame_bytes.push_back(kind);
    frame_bytes.push_back(flags);
    frame_bytes.push_back(hops);
    push_u64(dst_hi);
    push_u64(dst_lo);
    push_u64(src_hi);
    push_u64(src_lo);
    repeat (extra_bytes) frame_bytes.push_back(8'($urandom));
  endtask

  // Arbitrary bytes; first byte chosen by the caller
  task automatic make_raw(input int len, input logic [7:0] first);
    frame_bytes.push_back(first);
    repeat (len - 1) frame_bytes.push_back(8'($urandom));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Register writes go out only while the block is idle. The narrow
  // registers get junk in the upper data bits to check masking.
  task automatic write_reg(input logic [efc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic apply_settings(input efc_pkg::cfg_t s);
    logic [63:0] junk;
    junk = rand64();
    write_reg(efc_pkg::CFG_MY_ID_HIGH, s.my_id_high);
    write_reg(efc_pkg::CFG_MY_ID_LOW, s.my_id_low);
    write_reg(efc_pkg::CFG_GROUP_ID_HIGH, s.group_id_high);
    write_reg(efc_pkg::CFG_GROUP_ID_LOW, s.group_id_low);
    write_reg(efc_pkg::CFG_EXP_VERSION, {junk[63:8], s.expected_version});
    write_reg(efc_pkg::CFG_HOP_LIMIT, {junk[55:0], s.hop_limit});
    write_reg(efc_pkg::CFG_GATEWAY_MODE, {junk[62:0], s.gateway_mode});
    write_reg(CFG_UNMAPPED, rand64());
    cfg.valid <= 1'b0;
    live_cfg = s;
  endtask

  // Hold the sender until every outstanding verdict has been taken
  task automatic settle();
    frame_in.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (verdicts_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic efc_pkg::cfg_t random_settings(input int phase);
    efc_pkg::cfg_t s;
    s.my_id_high       = rand64();
    s.my_id_low        = rand64();
    s.group_id_high    = (phase == 0) ? 64'd0 : rand64();
    s.group_id_low     = (phase == 0) ? 64'd0 : rand64();
    s.expected_version = 8'($urandom);
    case ($urandom_range(0, 3))
      0:       s.hop_limit = 8'd0;
      1:       s.hop_limit = 8'hff;
      default: s.hop_limit = 8'($urandom);
    endcase
    s.gateway_mode = (phase % 2 == 0);
    return s;
  endfunction

  // Mostly well-formed headers steered towards the decision boundaries
  task automatic make_random_frame();
    logic [7:0]  ver;
    logic [7:0]  kind;
    logic [7:0]  hops;
    logic [63:0] dhi;
    logic [63:0] dlo;
    int          plen;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        make_raw($urandom_range(1, efc_pkg::HEADER_BYTES - 1),
                 ($urandom_range(0, 1) == 0) ? live_cfg.expected_version : 8'($urandom));
        return;
      end
      3, 4: begin
        make_raw($urandom_range(efc_pkg::HEADER_BYTES, efc_pkg::HEADER_BYTES + 12),
                 8'($urandom));
        return;
      end
      default: ;
    endcase
    ver = ($urandom_range(0, 9) != 0) ? live_cfg.expected_version : 8'($urandom);
    case ($urandom_range(0, 9))
      0:          kind = 8'($urandom);
      1:          kind = efc_pkg::TYPE_UNKNOWN;
      2, 3, 4:    kind = efc_pkg::TYPE_PEER;
      5, 6:       kind = efc_pkg::TYPE_GROUP;
      default:    kind = efc_pkg::TYPE_BROADCAST;
    endcase
    case ($urandom_range(0, 4))
      0: begin dhi = live_cfg.my_id_high;    dlo = live_cfg.my_id_low;    end
      1: begin dhi = live_cfg.group_id_high; dlo = live_cfg.group_id_low; end
      2: begin
        dhi = live_cfg.my_id_high;
        dlo = live_cfg.my_id_low ^ (64'd1 << $urandom_range(0, 63));
      end
      3: begin dhi = 64'd0; dlo = 64'd0; end
      default: begin dhi = rand64(); dlo = rand64(); end
    endcase
    case ($urandom_range(0, 3))
      0:       hops = live_cfg.hop_limit - 8'd1;
      1:       hops = live_cfg.hop_limit;
      2:       hops = 8'd0;
      default: hops = 8'($urandom);
    endcase
    plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
    make_frame(ver, kind, 8'($urandom), hops, dhi, dlo, rand64(), rand64(), plen);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    efc_pkg::cfg_t s;
    logic [63:0]   other_hi;
    int            phase_bytes;
    int            phase_frames;

    frame_in.valid      <= 1'b0;
    frame_in.frame_byte <= '0;
    frame_in.last_byte  <= 1'b0;
    cfg.valid           <= 1'b0;
    cfg.index           <= '0;
    cfg.data            <= '0;
    burst_left  = 0;
    live_cfg = '{my_id_high: '0, my_id_low: '0, group_id_high: '0, group_id_low: '0,
                 expected_version: efc_pkg::EXP_VERSION_RESET,
                 hop_limit: efc_pkg::HOP_LIMIT_RESET, gateway_mode: 1'b0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- reset settings: node id zero, no group, version 1, no gateway ---
    make_raw(1, efc_pkg::EXP_VERSION_RESET);              // one-byte frame
    send_frame();
    make_raw(efc_pkg::HEADER_BYTES - 1, 8'hff);           // short beats bad version
    send_frame();
    make_frame(efc_pkg::EXP_VERSION_RESET, efc_pkg::TYPE_BROADCAST, 8'h00, 8'h00,
               rand64(), rand64(), 64'd0, 64'd0, 0);      // header only
    send_frame();
    make_frame(8'h00, efc_pkg::TYPE_PEER, 8'h5a, 8'h01, 64'd0, 64'd0,
               rand64(), rand64(), 4);
    send_frame();
    make_frame(8'hff, efc_pkg::TYPE_BROADCAST, 8'h00, 8'h00, 64'd0, 64'd0,
               rand64(), rand64(), 3);
    send_frame();
    make_frame(efc_pkg::EXP_VERSION_RESET, efc_pkg::TYPE_PEER, 8'hff, 8'hff, 64'd0, 64'd0,
               64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5);  // addressed to us
    send_frame();
    make_frame(efc_pkg::EXP_VERSION_RESET, efc_pkg::TYPE_PEER, 8'h00, 8'h00,
               rand64(), rand64(), rand64(), rand64(), 2);  // not ours, no gateway
    send_frame();
    make_frame(efc_pkg::EXP_VERSION_RESET, efc_pkg::TYPE_GROUP, 8'h81, 8'h02, 64'd0, 64'd0,
               rand64(), rand64(), 1);                    // zero group never matches
    send_frame();
    make_frame(efc_pkg::EXP_VERSION_RESET, efc_pkg::TYPE_UNKNOWN, 8'h00, 8'h00,
               64'd0, 64'd0, rand64(), rand64(), 0);
    send_frame();
    make_frame(efc_pkg::EXP_VERSION_RESET, 8'hff, 8'h00, 8'h00, 64'd0, 64'd0,
               rand64(), rand64(), 0);                    // undefined type code
    send_frame();

    // --- all-ones id, version 255, hop limit 0, gateway on ---
    settle();
    s = '{my_id_high: '1, my_id_low: '1, group_id_high: rand64() | 64'd1,
          group_id_low: rand64(), expected_version: 8'hff, hop_limit: 8'h00,
          gateway_mode: 1'b1};
    apply_settings(s);
    make_frame(8'hff, efc_pkg::TYPE_PEER, 8'h00, 8'h00, '1, '1, rand64(), rand64(), 2);
    send_frame();
    make_frame(8'hff, efc_pkg::TYPE_PEER, 8'h00, 8'h00, rand64(), rand64(),
               rand64(), rand64(), 2);
    send_frame();                                          // hop 0 not below limit 0
    make_frame(8'hff, efc_pkg::TYPE_BROADCAST, 8'h00, 8'h00, '0, '0,
               rand64(), rand64(), 6);
    send_frame();
    make_frame(8'hff, efc_pkg::TYPE_GROUP, 8'h00, 8'h00, s.group_id_high, s.group_id_low,
               rand64(), rand64(), 3);
    send_frame();
    make_frame(8'hff, efc_pkg::TYPE_GROUP, 8'h00, 8'h00, s.group_id_high,
               s.group_id_low ^ 64'd1, rand64(), rand64(), 3);
    send_frame();

    // --- version 0, hop limit 255, no group, gateway on ---
    settle();
    s = '{my_id_high: rand64(), my_id_low: rand64(), group_id_high: '0, group_id_low: '0,
          expected_version: 8'h00, hop_limit: 8'hff, gateway_mode: 1'b1};
    apply_settings(s);
    other_hi = ~s.my_id_high;
    make_frame(8'h00, efc_pkg::TYPE_PEER, 8'h10, 8'hfe, other_hi, s.my_id_low,
               rand64(), rand64(), 1);                    // forwarded
    send_frame();
    make_frame(8'h00, efc_pkg::TYPE_PEER, 8'h10, 8'hff, other_hi, s.my_id_low,
               rand64(), rand64(), 1);                    // hop count at limit
    send_frame();
    make_frame(8'h00, efc_pkg::TYPE_BROADCAST, 8'h00, 8'hfe, '0, '0,
               rand64(), rand64(), 2);
    send_frame();                                          // rebroadcast
    make_frame(8'h00, efc_pkg::TYPE_GROUP, 8'h00, 8'h00, '0, '0, rand64(), rand64(), 2);
    send_frame();

    // --- random part, a fresh setting per phase ---
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      apply_settings(random_settings(ph));
      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < RANDOM_BYTES / RANDOM_PHASES ||
             phase_frames < MIN_FRAMES_PER_PHASE) begin
        make_random_frame();
        phase_bytes += frame_bytes.size();
        phase_frames++;
        send_frame();
        // once mid-stream, let the pipeline drain completely before carrying on
        if (ph == 1 && phase_frames == 1)
          settle();
      end
    end

    settle();
    if (verdict_fails == 0 && verdicts_pending == 0)
      $display("envelope_frame_classifier_unit_tb: PASS");
    else
      $display("envelope_frame_classifier_unit_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/efc_pkg.sv
hdl/efc_ifs.sv
hdl/efc_cfg_regs.sv
hdl/efc_parser.sv
hdl/efc_decide.sv
hdl/envelope_frame_classifier_unit.sv
bench/efc_verdict_checker.sv
bench/envelope_frame_classifier_unit_tb.sv
